FILE: src/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, codes and waveform tables of the I2C/SCCB master transaction engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam int SCRIPT_MAX = 16;

	typedef enum logic [2:0] {
		KIND_WR8, KIND_RD8, KIND_WR16, KIND_RD16,
		KIND_SCCB_WR, KIND_SCCB_RD, KIND_EXT_WR, KIND_EXT_RD
	} kind_t;

	typedef enum logic [3:0] {
		OP_W, OP_C0, OP_C1, OP_D0, OP_D1, OP_DB, OP_RL, OP_SD, OP_SA, OP_END
	} op_t;

	typedef enum logic [2:0] {
		TK_START, TK_STOP, TK_SEND, TK_RACK, TK_RECV, TK_SACK, TK_SNACK
	} tok_t;

	typedef struct packed {
		logic        mode;
		logic [2:0]  kind;
		logic [7:0]  dev_addr;
		logic [15:0] reg_addr;
		logic [15:0] write_data;
		logic [1:0]  addr_bytes;
		logic [1:0]  data_bytes;
		logic        sda_in;
	} in_word_t;

	typedef struct packed {
		logic        scl_level;
		logic        sda_level;
		logic        sda_drive;
		logic        busy_res;
		logic        done_res;
		logic [15:0] read_value;
		logic        ack_missed;
	} out_word_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  dev_addr;
		logic [15:0] reg_addr;
		logic [15:0] write_data;
		logic        two_addr;
		logic        two_data;
	} req_t;

	typedef struct packed {
		logic is_req;
		req_t req;
		logic sda;
	} cls_word_t;

	typedef struct packed {
		tok_t [SCRIPT_MAX-1:0]       kind;
		logic [SCRIPT_MAX-1:0][7:0] data;
		logic [3:0]                 count;
	} script_t;

	function automatic void add_tok(inout script_t s, input tok_t k, input logic [7:0] b);
		s.kind[s.count] = k;
		s.data[s.count] = b;
		s.count = s.count + 4'd1;
	endfunction

	function automatic script_t build_script(input req_t r);
		script_t s;
		logic [7:0] rdev;
		logic [7:0] reg_hi;
		logic [7:0] reg_lo;
		logic [7:0] dat_hi;
		logic [7:0] dat_lo;
		s = '0;
		rdev = r.dev_addr | 8'h01;
		reg_hi = r.reg_addr[15:8];
		reg_lo = r.reg_addr[7:0];
		dat_hi = r.write_data[15:8];
		dat_lo = r.write_data[7:0];
		add_tok(s, TK_START, 8'h00);
		add_tok(s, TK_SEND, r.dev_addr);
		add_tok(s, TK_RACK, 8'h00);
		case (r.kind)
			KIND_WR8: begin
				add_tok(s, TK_SEND, reg_lo); add_tok(s, TK_RACK, 8'h00);
				add_tok(s, TK_SEND, dat_lo);
			end
			KIND_RD8, KIND_SCCB_RD: begin
				add_tok(s, TK_SEND, reg_lo); add_tok(s, TK_RACK, 8'h00);
				if (r.kind == KIND_SCCB_RD) add_tok(s, TK_STOP, 8'h00);
				add_tok(s, TK_START, 8'h00);
				add_tok(s, TK_SEND, rdev); add_tok(s, TK_RACK, 8'h00);
				add_tok(s, TK_RECV, 8'h00); add_tok(s, TK_SACK, 8'h00);
			end
			KIND_WR16: begin
				add_tok(s, TK_SEND, reg_hi); add_tok(s, TK_RACK, 8'h00);
				add_tok(s, TK_SEND, reg_lo); add_tok(s, TK_RACK, 8'h00);
				add_tok(s, TK_SEND, dat_lo); add_tok(s, TK_RACK, 8'h00);
			end
			KIND_RD16: begin
				add_tok(s, TK_SEND, reg_hi); add_tok(s, TK_RACK, 8'h00);
				add_tok(s, TK_SEND, reg_lo); add_tok(s, TK_RACK, 8'h00);
				add_tok(s, TK_START, 8'h00);
				add_tok(s, TK_SEND, rdev); add_tok(s, TK_RACK, 8'h00);
				add_tok(s, TK_RECV, 8'h00);
			end
			KIND_SCCB_WR: begin
				add_tok(s, TK_SEND, reg_lo); add_tok(s, TK_RACK, 8'h00);
				add_tok(s, TK_SEND, dat_lo); add_tok(s, TK_RACK, 8'h00);
			end
			KIND_EXT_WR: begin
				if (r.two_addr) begin
					add_tok(s, TK_SEND, reg_hi); add_tok(s, TK_RACK, 8'h00);
				end
				add_tok(s, TK_SEND, reg_lo); add_tok(s, TK_RACK, 8'h00);
				if (r.two_data) begin
					add_tok(s, TK_SEND, dat_hi); add_tok(s, TK_RACK, 8'h00);
				end
				add_tok(s, TK_SEND, dat_lo);
			end
			default: begin
				if (r.two_addr) begin
					add_tok(s, TK_SEND, reg_hi); add_tok(s, TK_RACK, 8'h00);
				end
				add_tok(s, TK_SEND, reg_lo); add_tok(s, TK_RACK, 8'h00);
				add_tok(s, TK_START, 8'h00);
				add_tok(s, TK_SEND, rdev); add_tok(s, TK_RACK, 8'h00);
				if (r.two_data) begin
					add_tok(s, TK_RECV, 8'h00); add_tok(s, TK_SACK, 8'h00);
				end
				add_tok(s, TK_RECV, 8'h00); add_tok(s, TK_SNACK, 8'h00);
			end
		endcase
		add_tok(s, TK_STOP, 8'h00);
		return s;
	endfunction

	function automatic op_t fetch_op(input tok_t tk, input logic [3:0] sub,
			input logic [3:0] bitc);
		op_t op;
		op = OP_END;
		case (tk)
			TK_START: begin
				case (sub)
					4'd0: op = OP_W;  4'd1: op = OP_C1; 4'd2: op = OP_D1;
					4'd3: op = OP_W;  4'd4: op = OP_D0; 4'd5: op = OP_W;
					4'd6: op = OP_W;  default: op = OP_END;
				endcase
			end
			TK_STOP: begin
				case (sub)
					4'd1: op = OP_C1; 4'd3: op = OP_C0; 4'd5: op = OP_D0;
					4'd7: op = OP_C1; 4'd9: op = OP_D1;
					4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10: op = OP_W;
					default: op = OP_END;
				endcase
			end
			TK_RACK: begin
				case (sub)
					4'd1: op = OP_RL; 4'd3: op = OP_C0; 4'd5: op = OP_C1;
					4'd7: op = OP_RL; 4'd9: op = OP_SA; 4'd11: op = OP_C0;
					4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12: op = OP_W;
					default: op = OP_END;
				endcase
			end
			TK_SACK: begin
				case (sub)
					4'd1: op = OP_C0; 4'd3: op = OP_D1; 4'd5: op = OP_C1;
					4'd7: op = OP_C0; 4'd9: op = OP_D0;
					4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10: op = OP_W;
					default: op = OP_END;
				endcase
			end
			TK_SNACK: begin
				case (sub)
					4'd1: op = OP_D1; 4'd3: op = OP_C0; 4'd5: op = OP_C1;
					4'd7: op = OP_C0; 4'd9: op = OP_D0;
					4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10: op = OP_W;
					default: op = OP_END;
				endcase
			end
			TK_SEND: begin
				if (bitc < 4'd8) begin
					case (sub)
						4'd1: op = OP_C0; 4'd3: op = OP_DB; 4'd5: op = OP_C1;
						4'd7: op = OP_C0;
						4'd0, 4'd2, 4'd4, 4'd6: op = OP_W;
						default: op = OP_END;
					endcase
				end else begin
					op = (sub == 4'd0) ? OP_W : OP_END;
				end
			end
			TK_RECV: begin
				if (bitc < 4'd8) begin
					case (sub)
						4'd1: op = OP_C0; 4'd4: op = OP_C1; 4'd5: op = OP_RL;
						4'd7: op = OP_RL; 4'd9: op = OP_SD; 4'd11: op = OP_C0;
						4'd0, 4'd2, 4'd3, 4'd6, 4'd8, 4'd10: op = OP_W;
						default: op = OP_END;
					endcase
				end else begin
					op = (sub == 4'd0) ? OP_W : OP_END;
				end
			end
			default: op = OP_END;
		endcase
		return op;
	endfunction

endpackage

FILE: src/i2cm_stream_if.sv
// ----------------------------------------------------------------------------
// i2cm_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface i2cm_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: src/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts input words and classifies them into ticks and requests.
// ----------------------------------------------------------------------------
module i2cm_front (
	i2cm_stream_if.sink   in_ch,
	i2cm_stream_if.source cls_ch
);
	import i2cm_pkg::*;

	cls_word_t cls;

	always_comb begin
		cls.is_req          = in_ch.data.mode;
		cls.req.kind        = kind_t'(in_ch.data.kind);
		cls.req.dev_addr    = in_ch.data.dev_addr;
		cls.req.reg_addr    = in_ch.data.reg_addr;
		cls.req.write_data  = in_ch.data.write_data;
		cls.req.two_addr    = (in_ch.data.addr_bytes == 2'd2);
		cls.req.two_data    = (in_ch.data.data_bytes == 2'd2);
		cls.sda             = in_ch.data.sda_in;
	end

	assign cls_ch.valid = in_ch.valid;
	assign cls_ch.data  = cls;
	assign in_ch.ready  = cls_ch.ready;
endmodule

FILE: src/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue
// Small FIFO between the classifier and the bit engine.
// ----------------------------------------------------------------------------
module i2cm_queue #(
	parameter int DEPTH = 2
) (
	input logic           clk,
	input logic           arst_n,
	i2cm_stream_if.sink   push_ch,
	i2cm_stream_if.source pop_ch
);
	import i2cm_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cls_word_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            push;
	logic            pop;

	assign push_ch.ready = (cnt_q != CW'(DEPTH));
	assign pop_ch.valid  = (cnt_q != '0);
	assign pop_ch.data   = mem_q[rd_ptr_q];
	assign push = push_ch.valid && push_ch.ready;
	assign pop  = pop_ch.valid && pop_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_ch.data;
	end
endmodule

FILE: src/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back
// Bit engine: runs the transaction script into an output register, one word
// per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module i2cm_back (
	input logic           clk,
	input logic           arst_n,
	input logic           cfg_wr_en,
	input logic [15:0]    cfg_wr_data,
	i2cm_stream_if.sink   cls_ch,
	i2cm_stream_if.source out_ch
);
	import i2cm_pkg::*;

	script_t     script_q, script_d;
	logic        busy_q, busy_d;
	logic [3:0]  phase_q, phase_d;
	logic [3:0]  sub_q, sub_d;
	logic [3:0]  bit_q, bit_d;
	logic [15:0] unit_q, unit_d;
	logic [2:0]  pin_q, pin_d;
	logic [15:0] rd_q, rd_d;
	logic        ack_q, ack_d;
	logic [15:0] dut_q;
	logic        out_valid_q;
	out_word_t   out_data_q;
	logic        pop;
	logic        done;
	logic        stop;
	logic [16:0] cnt1;
	logic [15:0] lim;
	logic [7:0]  cur_byte;
	tok_t        cur_tok;
	op_t         op;

	assign pop = cls_ch.valid && (!out_valid_q || out_ch.ready);
	assign cls_ch.ready = !out_valid_q || out_ch.ready;
	assign lim  = (dut_q == 16'd0) ? 16'd1 : dut_q;
	assign cnt1 = {1'b0, unit_q} + 17'd1;

	always_comb begin
		script_d = script_q;
		busy_d   = busy_q;
		phase_d  = phase_q;
		sub_d    = sub_q;
		bit_d    = bit_q;
		unit_d   = unit_q;
		pin_d    = pin_q;
		rd_d     = rd_q;
		ack_d    = ack_q;
		done     = 1'b0;
		stop     = 1'b0;
		cur_tok  = script_q.kind[phase_q];
		cur_byte = script_q.data[phase_q];
		op       = OP_W;
		if (pop) begin
			if (cls_ch.data.is_req) begin
				if (!busy_q) begin
					script_d = build_script(cls_ch.data.req);
					busy_d   = 1'b1;
					phase_d  = '0;
					sub_d    = '0;
					bit_d    = '0;
					unit_d   = '0;
					rd_d     = '0;
					ack_d    = 1'b0;
				end
			end else if (busy_q) begin
				if (cnt1 >= {1'b0, lim}) begin
					sub_d = sub_q + 4'd1;
					for (int i = 0; i < 3; i++) begin
						if (!stop) begin
							op = fetch_op(cur_tok, sub_d, bit_d);
							case (op)
								OP_W: begin
									stop   = 1'b1;
									unit_d = '0;
								end
								OP_END: begin
									stop = 1'b1;
									if ({1'b0, phase_q} + 5'd1 >= {1'b0, script_q.count}) begin
										busy_d = 1'b0;
										done   = 1'b1;
									end else begin
										phase_d = phase_q + 4'd1;
										sub_d   = '0;
										bit_d   = '0;
										unit_d  = '0;
									end
								end
								OP_C0: pin_d[0] = 1'b0;
								OP_C1: pin_d[0] = 1'b1;
								OP_D0: pin_d[2:1] = 2'b10;
								OP_D1: pin_d[2:1] = 2'b11;
								OP_DB: pin_d[2:1] = {1'b1, cur_byte[3'(4'd7 - bit_d)]};
								OP_RL: pin_d[2:1] = 2'b00;
								OP_SD: rd_d = {rd_d[14:0], cls_ch.data.sda};
								OP_SA: ack_d = ack_d | cls_ch.data.sda;
								default: stop = 1'b1;
							endcase
							if (!stop) begin
								// last action of a bit slot wraps to the next bit
								if ((cur_tok == TK_SEND && sub_d == 4'd7) ||
										(cur_tok == TK_RECV && sub_d == 4'd11)) begin
									sub_d = '0;
									bit_d = bit_d + 4'd1;
								end else begin
									sub_d = sub_d + 4'd1;
								end
							end
						end
					end
				end else begin
					unit_d = cnt1[15:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= '0;
			sub_q       <= '0;
			bit_q       <= '0;
			unit_q      <= '0;
			pin_q       <= 3'b001;
			rd_q        <= '0;
			ack_q       <= 1'b0;
			dut_q       <= 16'd1;
			out_valid_q <= 1'b0;
			script_q    <= '0;
		end else begin
			busy_q   <= busy_d;
			phase_q  <= phase_d;
			sub_q    <= sub_d;
			bit_q    <= bit_d;
			unit_q   <= unit_d;
			pin_q    <= pin_d;
			rd_q     <= rd_d;
			ack_q    <= ack_d;
			script_q <= script_d;
			if (cfg_wr_en)
				dut_q <= cfg_wr_data;
			if (pop)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q.scl_level  <= pin_d[0];
			out_data_q.sda_level  <= pin_d[2] & pin_d[1];
			out_data_q.sda_drive  <= pin_d[2];
			out_data_q.busy_res   <= busy_d;
			out_data_q.done_res   <= done;
			out_data_q.read_value <= rd_d;
			out_data_q.ack_missed <= ack_d;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;
endmodule

FILE: src/i2c_master_transaction_engine_core.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_engine_core
// Bit-banged I2C/SCCB master: requests start a transaction, ticks advance it.
// ----------------------------------------------------------------------------
// channel   dir  word         handshake
// in_ch     in   in_word_t    valid/ready
// out_ch    out  out_word_t   valid/ready
// cfg       in   16b ticks    cfg_wr_en strobe
//
// One word per cycle unless stalled; result via queue and output register.
// The output register and the queue let each side stall independently.
// Reset: SCL high, SDA released, idle, one tick per delay unit.
// ----------------------------------------------------------------------------
module i2c_master_transaction_engine_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_wr_en,
	input logic [15:0]  cfg_wr_data,
	i2cm_stream_if.sink   in_ch,
	i2cm_stream_if.source out_ch
);
	import i2cm_pkg::*;

	i2cm_stream_if #(.T(cls_word_t)) cls_ch ();
	i2cm_stream_if #(.T(cls_word_t)) q_ch ();

	i2cm_front u_front (
		.in_ch  (in_ch),
		.cls_ch (cls_ch)
	);

	i2cm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_ch (cls_ch),
		.pop_ch  (q_ch)
	);

	i2cm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cls_ch      (q_ch),
		.out_ch      (out_ch)
	);
endmodule

FILE: src/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks of the transaction engine.
// ----------------------------------------------------------------------------
module i2cm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input i2cm_pkg::out_word_t out_data
);
	import i2cm_pkg::*;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("done with busy set");

	a_sda_driven: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sda_level |-> out_data.sda_drive)
		else $error("sda level high while released");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word dropped under stall");
endmodule

bind i2c_master_transaction_engine_core i2cm_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
